/* rtl/rti_pkg.sv */
// Shared constants and types for the ray/triangle intersection core.
package rti_pkg;

  localparam int unsigned DIST_W = 32;
  localparam int unsigned T_FRAC = 16;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned EPS_W  = 32;

  localparam logic [IDX_W-1:0] REG_VERTEX_A    = 8'd0;
  localparam logic [IDX_W-1:0] REG_VERTEX_B    = 8'd1;
  localparam logic [IDX_W-1:0] REG_VERTEX_C    = 8'd2;
  localparam logic [IDX_W-1:0] REG_DET_EPSILON = 8'd3;

  localparam logic [DIST_W-1:0] DIST_SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic hit;
    logic tneg;
    logic ovf;
  } rti_flags_t;

endpackage

/* rtl/rti_geom.sv */
// Geometry pipeline: edges, cross products, dot products, sign fold, inside tests, overflow check and divider seed.
module rti_geom #(
  parameter int unsigned W = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [6*W-1:0]             in_data,
  input  logic [3*W-1:0]             vertex_a,
  input  logic [3*W-1:0]             vertex_b,
  input  logic [3*W-1:0]             vertex_c,
  input  logic [rti_pkg::EPS_W-1:0]  det_eps,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [3*W+5:0]             out_rem,
  output logic [3*W+5:0]             out_den,
  output logic [rti_pkg::DIST_W-1:0] out_word,
  output rti_pkg::rti_flags_t        out_flags
);

  localparam int unsigned EW = W + 1;
  localparam int unsigned PW = 2 * W + 2;
  localparam int unsigned QW = 2 * W + 3;
  localparam int unsigned MW = 3 * W + 4;
  localparam int unsigned SW = 3 * W + 6;
  localparam int unsigned TF = rti_pkg::T_FRAC;
  localparam int unsigned DW = rti_pkg::DIST_W;
  localparam int unsigned EPS_PAD = rti_pkg::EPS_W;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

  assign rdy7     = !v7_r || out_ready;
  assign rdy6     = !v6_r || rdy7;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
    end
  end

  // stage 1: edges and origin offset
  logic signed [EW-1:0] e0_nxt [3], e1_nxt [3], s_nxt [3];
  logic signed [W-1:0]  d_nxt [3];
  logic signed [EW-1:0] e0_r [3], e1_r [3], s_r [3];
  logic signed [W-1:0]  d_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e0_nxt[k] = signed'(vertex_b[k*W +: W]) - signed'(vertex_a[k*W +: W]);
      e1_nxt[k] = signed'(vertex_c[k*W +: W]) - signed'(vertex_a[k*W +: W]);
      s_nxt[k]  = signed'(in_data[k*W +: W]) - signed'(vertex_a[k*W +: W]);
      d_nxt[k]  = signed'(in_data[(3+k)*W +: W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      e0_r <= e0_nxt; e1_r <= e1_nxt; s_r <= s_nxt; d_r <= d_nxt;
    end
  end

  // stage 2: p = d x e1, q = s x e0
  logic signed [PW-1:0] p_nxt [3], p_r [3];
  logic signed [QW-1:0] q_nxt [3], q_r [3];
  logic signed [EW-1:0] e0_2r [3], e1_2r [3], s_2r [3];
  logic signed [W-1:0]  d_2r [3];

  always_comb begin
    p_nxt[0] = d_r[1] * e1_r[2] - d_r[2] * e1_r[1];
    p_nxt[1] = d_r[2] * e1_r[0] - d_r[0] * e1_r[2];
    p_nxt[2] = d_r[0] * e1_r[1] - d_r[1] * e1_r[0];
    q_nxt[0] = s_r[1] * e0_r[2] - s_r[2] * e0_r[1];
    q_nxt[1] = s_r[2] * e0_r[0] - s_r[0] * e0_r[2];
    q_nxt[2] = s_r[0] * e0_r[1] - s_r[1] * e0_r[0];
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p_r <= p_nxt; q_r <= q_nxt;
      e0_2r <= e0_r; e1_2r <= e1_r; s_2r <= s_r; d_2r <= d_r;
    end
  end

  // stage 3: element products of the four dot products
  logic signed [MW-1:0] mdet_nxt [3], mu_nxt [3], mv_nxt [3], mt_nxt [3];
  logic signed [MW-1:0] mdet_r [3], mu_r [3], mv_r [3], mt_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mdet_nxt[k] = e0_2r[k] * p_r[k];
      mu_nxt[k]   = s_2r[k] * p_r[k];
      mv_nxt[k]   = d_2r[k] * q_r[k];
      mt_nxt[k]   = e1_2r[k] * q_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      mdet_r <= mdet_nxt; mu_r <= mu_nxt; mv_r <= mv_nxt; mt_r <= mt_nxt;
    end
  end

  // stage 4: sums
  logic signed [SW-1:0] det4_r, u4_r, v4s_r, t4_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      det4_r <= SW'(mdet_r[0]) + SW'(mdet_r[1]) + SW'(mdet_r[2]);
      u4_r   <= SW'(mu_r[0]) + SW'(mu_r[1]) + SW'(mu_r[2]);
      v4s_r  <= SW'(mv_r[0]) + SW'(mv_r[1]) + SW'(mv_r[2]);
      t4_r   <= SW'(mt_r[0]) + SW'(mt_r[1]) + SW'(mt_r[2]);
    end
  end

  // stage 5: fold the determinant sign
  logic signed [SW-1:0] det5_r, u5_r, v5s_r, t5_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      if (det4_r[SW-1]) begin
        det5_r <= -det4_r; u5_r <= -u4_r; v5s_r <= -v4s_r; t5_r <= -t4_r;
      end else begin
        det5_r <= det4_r; u5_r <= u4_r; v5s_r <= v4s_r; t5_r <= t4_r;
      end
    end
  end

  // stage 6: inside tests and magnitude of T
  logic signed [SW:0]   uv_sum;
  logic                 hit_nxt;
  logic [SW-1:0]        tabs_nxt;
  logic [SW-1:0]        det6_r, tabs6_r;
  logic                 hit6_r, tneg6_r;

  always_comb begin
    uv_sum   = u5_r + v5s_r;
    hit_nxt  = ({{EPS_PAD{1'b0}}, det5_r} > {{SW{1'b0}}, det_eps}) &&
               !u5_r[SW-1] && !(u5_r > det5_r) &&
               !v5s_r[SW-1] && !(uv_sum > det5_r);
    tabs_nxt = t5_r[SW-1] ? SW'(-t5_r) : SW'(t5_r);
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      det6_r  <= det5_r;
      tabs6_r <= tabs_nxt;
      hit6_r  <= hit_nxt;
      tneg6_r <= t5_r[SW-1];
    end
  end

  // stage 7: quotient overflow check and divider seed
  logic [SW-1:0]       rem7_r, den7_r;
  logic [DW-1:0]       word7_r;
  rti_pkg::rti_flags_t flags7_r;

  always_ff @(posedge clk) begin
    if (rdy7) begin
      rem7_r         <= tabs6_r >> TF;
      den7_r         <= det6_r;
      word7_r        <= {tabs6_r[TF-1:0], {(DW-TF){1'b0}}};
      flags7_r.hit   <= hit6_r;
      flags7_r.tneg  <= tneg6_r;
      flags7_r.ovf   <= {{TF{1'b0}}, tabs6_r} >= {det6_r, {TF{1'b0}}};
    end
  end

  assign out_valid = v7_r;
  assign out_rem   = rem7_r;
  assign out_den   = den7_r;
  assign out_word  = word7_r;
  assign out_flags = flags7_r;

endmodule

/* rtl/rti_div_step.sv */
// One restoring-division stage: one quotient bit per request.
module rti_div_step #(
  parameter int unsigned W = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [3*W+5:0]             in_rem,
  input  logic [3*W+5:0]             in_den,
  input  logic [rti_pkg::DIST_W-1:0] in_word,
  input  rti_pkg::rti_flags_t        in_flags,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [3*W+5:0]             out_rem,
  output logic [3*W+5:0]             out_den,
  output logic [rti_pkg::DIST_W-1:0] out_word,
  output rti_pkg::rti_flags_t        out_flags
);

  localparam int unsigned SW = 3 * W + 6;
  localparam int unsigned DW = rti_pkg::DIST_W;

  logic                v_r;
  logic [SW-1:0]       rem_r, den_r, rem_nxt;
  logic [DW-1:0]       word_r;
  rti_pkg::rti_flags_t flags_r;
  logic [SW:0]         trial;
  logic                ge;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    trial   = {in_rem, in_word[DW-1]};
    ge      = trial >= {1'b0, in_den};
    rem_nxt = ge ? SW'(trial - {1'b0, in_den}) : trial[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem_r   <= rem_nxt;
      den_r   <= in_den;
      word_r  <= {in_word[DW-2:0], ge};
      flags_r <= in_flags;
    end
  end

  assign out_valid = v_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_word  = word_r;
  assign out_flags = flags_r;

endmodule

/* rtl/ray_triangle_intersect_core.sv */
// Top level of the pipelined ray/triangle intersection core.
// Usage:
//   Load the triangle through the cfg_ channel: index 0..2 write vertices a, b, c
//   (x low, z high, COORD_WIDTH bits each), index 3 writes the determinant epsilon.
//   cfg_ready is always high; writes to other indexes are dropped.
//   Each request on in_ carries one ray (origin x,y,z then direction x,y,z).
//   Each ray yields one request on out_: tuser is the hit flag, tdata the signed
//   Q16.16 distance, saturated, zero on a miss.
// Throughput: one ray per cycle without stalls, set by the 7-stage geometry pipeline and the
//   32-stage restoring divider (one quotient bit per stage).
// Stalls: every stage holds its request while the next one is full and stalled; empty
//   stages keep filling, so in_tready stays high until the whole pipe is full.
// Reset: synchronous rst_n clears all valid bits and loads vertices 0, epsilon 1.
module ray_triangle_intersect_core #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [8*((6*COORD_WIDTH+7)/8)-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // distance
  output logic [rti_pkg::DIST_W-1:0]             out_tdata,
  // hit
  output logic                                   out_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rti_pkg::IDX_W-1:0]              cfg_index,
  input  logic [((3*COORD_WIDTH > 32) ? 3*COORD_WIDTH : 32)-1:0] cfg_data
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned SW = 3 * W + 6;
  localparam int unsigned DW = rti_pkg::DIST_W;
  localparam int unsigned NS = rti_pkg::DIST_W;

  logic [3*W-1:0]               vert_a_r, vert_b_r, vert_c_r;
  logic [rti_pkg::EPS_W-1:0]    eps_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vert_a_r <= '0;
      vert_b_r <= '0;
      vert_c_r <= '0;
      eps_r    <= rti_pkg::EPS_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        rti_pkg::REG_VERTEX_A:    vert_a_r <= cfg_data[3*W-1:0];
        rti_pkg::REG_VERTEX_B:    vert_b_r <= cfg_data[3*W-1:0];
        rti_pkg::REG_VERTEX_C:    vert_c_r <= cfg_data[3*W-1:0];
        rti_pkg::REG_DET_EPSILON: eps_r    <= cfg_data[rti_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  logic                v_c   [NS+1];
  logic                rdy_c [NS+1];
  logic [SW-1:0]       rem_c [NS+1];
  logic [SW-1:0]       den_c [NS+1];
  logic [DW-1:0]       word_c [NS+1];
  rti_pkg::rti_flags_t flags_c [NS+1];

  rti_geom #(.W(W)) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata[6*W-1:0]),
    .vertex_a  (vert_a_r),
    .vertex_b  (vert_b_r),
    .vertex_c  (vert_c_r),
    .det_eps   (eps_r),
    .out_valid (v_c[0]),
    .out_ready (rdy_c[0]),
    .out_rem   (rem_c[0]),
    .out_den   (den_c[0]),
    .out_word  (word_c[0]),
    .out_flags (flags_c[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_div
    rti_div_step #(.W(W)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_c[g]),
      .in_ready  (rdy_c[g]),
      .in_rem    (rem_c[g]),
      .in_den    (den_c[g]),
      .in_word   (word_c[g]),
      .in_flags  (flags_c[g]),
      .out_valid (v_c[g+1]),
      .out_ready (rdy_c[g+1]),
      .out_rem   (rem_c[g+1]),
      .out_den   (den_c[g+1]),
      .out_word  (word_c[g+1]),
      .out_flags (flags_c[g+1])
    );
  end

  // output stage: saturate and sign the quotient
  logic          out_v_r, hit_r;
  logic [DW-1:0] dist_r, dist_nxt, quo;
  rti_pkg::rti_flags_t fl;

  assign rdy_c[NS] = !out_v_r || out_tready;
  assign quo       = word_c[NS];
  assign fl        = flags_c[NS];

  always_comb begin
    if (!fl.hit) begin
      dist_nxt = '0;
    end else if (fl.tneg) begin
      dist_nxt = (fl.ovf || quo[DW-1]) ? rti_pkg::DIST_SAT_NEG : DW'(-quo);
    end else begin
      dist_nxt = (fl.ovf || quo[DW-1]) ? rti_pkg::DIST_SAT_POS : quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy_c[NS]) begin
      out_v_r <= v_c[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c[NS]) begin
      dist_r <= dist_nxt;
      hit_r  <= fl.hit;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = dist_r;
  assign out_tuser  = hit_r;

  // rem and den of the last stage are not needed past the final quotient bit
  logic unused_tail;
  assign unused_tail = ^{rem_c[NS], den_c[NS]};

endmodule

/* tb/sv/tb_ray_triangle_intersect_core.sv */
// Testbench for the ray/triangle intersection core: random and directed rays checked against an exact predictor.
`timescale 1ns / 100ps

module tb_ray_triangle_intersect_core;

  localparam int CW = 16;
  localparam int DW = 8 * ((6 * CW + 7) / 8);
  localparam int CFGW = (3 * CW > 32) ? 3 * CW : 32;
  localparam int LIMIT = 2000000;

  typedef struct {
    logic hit;
    logic [31:0] dist_val;
  } isect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rti_pkg::IDX_W-1:0] cfg_index = '0;
  logic [CFGW-1:0] cfg_data = '0;

  logic [47:0] tri_a, tri_b, tri_c;
  logic [31:0] eps;
  logic [DW-1:0] ray_q[$];
  isect_t hit_q[$];
  int errors = 0;
  int cycles = 0;
  int gap = 0;
  int stall = 0;
  bit hold_send = 1'b0;
  bit sent_all = 1'b0;

  ray_triangle_intersect_core #(.COORD_WIDTH(CW)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [127:0] crd(logic [47:0] v, int k);
    return 128'(signed'(v[k*16 +: 16]));
  endfunction

  function automatic isect_t predict_hit(logic [DW-1:0] ray);
    logic signed [127:0] e0[3], e1[3], s[3], d[3], p[3], q[3];
    logic signed [127:0] det, uu, vv, tt;
    logic [127:0] quo;
    isect_t r;
    for (int k = 0; k < 3; k++) begin
      e0[k] = crd(tri_b, k) - crd(tri_a, k);
      e1[k] = crd(tri_c, k) - crd(tri_a, k);
      s[k] = 128'(signed'(ray[k*16 +: 16])) - crd(tri_a, k);
      d[k] = 128'(signed'(ray[(k+3)*16 +: 16]));
    end
    p[0] = d[1]*e1[2] - d[2]*e1[1];
    p[1] = d[2]*e1[0] - d[0]*e1[2];
    p[2] = d[0]*e1[1] - d[1]*e1[0];
    q[0] = s[1]*e0[2] - s[2]*e0[1];
    q[1] = s[2]*e0[0] - s[0]*e0[2];
    q[2] = s[0]*e0[1] - s[1]*e0[0];
    det = e0[0]*p[0] + e0[1]*p[1] + e0[2]*p[2];
    uu = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
    vv = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
    tt = e1[0]*q[0] + e1[1]*q[1] + e1[2]*q[2];
    if (det < 0) begin
      det = -det; uu = -uu; vv = -vv; tt = -tt;
    end
    r.hit = 1'b0;
    r.dist_val = '0;
    if (det <= $signed({96'd0, eps}) || uu < 0 || uu > det || vv < 0 || uu + vv > det)
      return r;
    r.hit = 1'b1;
    quo = ((tt < 0 ? -tt : tt) <<< rti_pkg::T_FRAC) / det;
    if (tt < 0) r.dist_val = (quo >= 128'h8000_0000) ? rti_pkg::DIST_SAT_NEG : 32'(-quo);
    else r.dist_val = (quo > 128'h7FFF_FFFF) ? rti_pkg::DIST_SAT_POS : quo[31:0];
    return r;
  endfunction

  function automatic logic [15:0] rcoord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3: return 16'($urandom_range(0, 2047)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] rvert(bit wide_rng);
    logic [47:0] v;
    for (int k = 0; k < 3; k++)
      v[k*16 +: 16] = wide_rng ? 16'($urandom) : 16'($urandom_range(0, 1023)) - 16'd512;
    return v;
  endfunction

  // ray aimed at a point inside (mostly) the triangle
  function automatic logic [DW-1:0] aimed_ray();
    logic [DW-1:0] ray;
    int wa, wb, wc, tot;
    logic signed [31:0] pt, o;
    wa = $urandom_range(0, 100); wb = $urandom_range(0, 100); wc = $urandom_range(0, 100);
    tot = wa + wb + wc + 1;
    for (int k = 0; k < 3; k++) begin
      pt = (32'(signed'(tri_a[k*16 +: 16])) * wa + 32'(signed'(tri_b[k*16 +: 16])) * wb
            + 32'(signed'(tri_c[k*16 +: 16])) * wc) / tot;
      o = 32'(signed'(16'($urandom_range(0, 4095)) - 16'd2048));
      ray[k*16 +: 16] = 16'(o);
      ray[(k+3)*16 +: 16] = 16'(pt - o);
    end
    return ray;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        hit_q.push_back(predict_hit(in_tdata));
        void'(ray_q.pop_front());
      end
      if (in_tvalid && !in_tready) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_tvalid <= 1'b0;
      end else if (hold_send) begin
        in_tvalid <= 1'b0;
      end else if (ray_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= ray_q[0];
        gap <= gap_len();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (hit_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result hit=%0b dist=%h", out_tuser, out_tdata);
        end else begin
          if (out_tuser !== hit_q[0].hit || out_tdata !== hit_q[0].dist_val) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: exp hit=%0b dist=%h got hit=%0b dist=%h",
                       hit_q[0].hit, hit_q[0].dist_val, out_tuser, out_tdata);
          end
          void'(hit_q.pop_front());
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  task automatic wait_drain();
    while (ray_q.size() > 0 || in_tvalid || hit_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [rti_pkg::IDX_W-1:0] idx, logic [CFGW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rti_pkg::REG_VERTEX_A: tri_a = val[47:0];
      rti_pkg::REG_VERTEX_B: tri_b = val[47:0];
      rti_pkg::REG_VERTEX_C: tri_c = val[47:0];
      rti_pkg::REG_DET_EPSILON: eps = val[31:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_triangle(logic [47:0] a, logic [47:0] b, logic [47:0] c, logic [31:0] e);
    write_reg(rti_pkg::REG_VERTEX_A, CFGW'(a));
    write_reg(rti_pkg::REG_VERTEX_B, CFGW'(b));
    write_reg(rti_pkg::REG_VERTEX_C, CFGW'(c));
    write_reg(rti_pkg::REG_DET_EPSILON, CFGW'(e));
  endtask

  function automatic logic [DW-1:0] pack_ray(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                                             logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
    return {dz, dy, dx, oz, oy, ox};
  endfunction

  initial begin
    logic [DW-1:0] r;
    tri_a = '0; tri_b = '0; tri_c = '0; eps = 32'd1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // degenerate triangle at reset values
    ray_q.push_back(pack_ray(0, 0, 0, 16'h0100, 0, 0));
    wait_drain();

    // unit triangle in z=0, rays mostly along -z
    load_triangle({16'h0, 16'h0, 16'h0}, {16'h0, 16'h0, 16'h0100},
                  {16'h0, 16'h0100, 16'h0}, 32'd0);
    ray_q.push_back(pack_ray(16'h0040, 16'h0040, 16'h0100, 0, 0, 16'hFF00));
    ray_q.push_back(pack_ray(0, 0, 16'h0100, 0, 0, 16'hFF00));              // vertex
    ray_q.push_back(pack_ray(16'h0100, 0, 16'h0100, 0, 0, 16'hFF00));       // vertex
    ray_q.push_back(pack_ray(16'h0080, 16'h0080, 16'h0100, 0, 0, 16'hFF00)); // edge
    ray_q.push_back(pack_ray(16'h0081, 16'h0080, 16'h0100, 0, 0, 16'hFF00)); // outside
    ray_q.push_back(pack_ray(16'hFFFF, 16'h0010, 16'h0100, 0, 0, 16'hFF00)); // u<0
    ray_q.push_back(pack_ray(16'h0040, 16'h0040, 16'hFF00, 0, 0, 16'hFF00)); // t<0
    ray_q.push_back(pack_ray(16'h0040, 16'h0040, 16'h0100, 0, 0, 16'h0100)); // back face
    ray_q.push_back(pack_ray(16'h0040, 16'h0040, 16'h0100, 16'h0100, 0, 0)); // parallel
    ray_q.push_back(pack_ray(16'h0010, 16'h0010, 16'h7FFF, 0, 0, 16'hFFFF)); // near sat pos
    ray_q.push_back(pack_ray(16'h0010, 16'h0010, 16'h8000, 0, 0, 16'hFFFF)); // sat neg
    ray_q.push_back(pack_ray(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    ray_q.push_back(pack_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
    ray_q.push_back({DW{1'b1}});
    wait_drain();

    // epsilon at max, extreme vertices
    write_reg(rti_pkg::REG_DET_EPSILON, CFGW'(32'hFFFF_FFFF));
    ray_q.push_back(pack_ray(16'h0040, 16'h0040, 16'h0100, 0, 0, 16'hFF00));
    wait_drain();
    load_triangle({16'h8000, 16'h8000, 16'h8000}, {16'h7FFF, 16'h7FFF, 16'h8000},
                  {16'h8000, 16'h7FFF, 16'h7FFF}, 32'd1);
    write_reg(8'd7, {CFGW{1'b1}}); // unknown index, dropped
    ray_q.push_back(pack_ray(0, 0, 0, 16'h0100, 16'h0100, 16'h0100));
    ray_q.push_back(pack_ray(0, 0, 0, 16'hFF00, 16'h0100, 16'hFF00));
    wait_drain();

    for (int ph = 0; ph < 13; ph++) begin
      load_triangle(rvert(ph % 4 == 3), rvert(ph % 4 == 3), rvert(ph % 4 == 3),
                    (ph % 5 == 0) ? 32'd0 : (ph % 5 == 4) ? $urandom : 32'($urandom_range(0, 255)));
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 3) != 0) r = aimed_ray();
        else r = pack_ray(rcoord(), rcoord(), rcoord(), rcoord(), rcoord(), rcoord());
        ray_q.push_back(r);
        if (ph == 6 && i == 75) begin
          while (ray_q.size() > 0 || in_tvalid) @(posedge clk);
          hold_send = 1'b1;
          while (hit_q.size() > 0) @(posedge clk);
          hold_send = 1'b0;
        end
      end
      wait_drain();
    end

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
rtl/rti_pkg.sv
rtl/rti_geom.sv
rtl/rti_div_step.sv
rtl/ray_triangle_intersect_core.sv
tb/sv/tb_ray_triangle_intersect_core.sv
